// ===== sv/tmse_pkg.sv =====
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types and codes of the three-symbol Turing machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

    localparam int NUM_STATES    = 8;
    localparam int NUM_RULE_REGS = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int FIELD_POS_W   = 12;
    localparam int OFFSET_W      = 12;
    localparam int COUNT_W       = 32;

    typedef logic [2:0] t_state;
    typedef logic [1:0] t_symbol;
    typedef logic [1:0] t_move;
    typedef logic [1:0] t_status;
    typedef logic [3:0] t_count_cfg;

    typedef struct packed {
        t_symbol wr;
        t_move   mv;
        t_state  nx;
    } t_rule;

    localparam t_state STATE_HALT = 3'd0;
    localparam t_state STATE_INIT = 3'd1;

    localparam t_symbol SYM_BLANK   = 2'd0;
    localparam t_symbol SYM_INVALID = 2'd3;

    localparam t_move MOVE_LEFT  = 2'd0;
    localparam t_move MOVE_RIGHT = 2'd1;
    localparam t_move MOVE_STAY  = 2'd2;
    localparam t_move MOVE_BAD   = 2'd3;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_BAD_RULE    = 2'd1;
    localparam t_status ST_TAPE_END    = 2'd2;
    localparam t_status ST_READ_BEYOND = 2'd3;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 3'd0;
    localparam t_count_cfg STATE_COUNT_RESET = 4'd8;

endpackage

// ===== sv/tmse_tape_ram.sv =====
// ----------------------------------------------------------------------------
// tmse_tape_ram
// Tape store: one write port, two registered read ports, write-first bypass.
// ----------------------------------------------------------------------------
module tmse_tape_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr_a,
    input  logic [AW-1:0]         i_rd_addr_b,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  tmse_pkg::t_symbol     i_wr_data,
    output tmse_pkg::t_symbol     o_rd_data_a,
    output tmse_pkg::t_symbol     o_rd_data_b
);
    import tmse_pkg::*;

    t_symbol mem [0:DEPTH-1];
    t_symbol r_rd_a;
    t_symbol r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
                r_rd_a <= i_wr_data;
            end else begin
                r_rd_a <= mem[i_rd_addr_a];
            end
            if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
                r_rd_b <= i_wr_data;
            end else begin
                r_rd_b <= mem[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== sv/tmse_rule_bank.sv =====
// ----------------------------------------------------------------------------
// tmse_rule_bank
// Configuration registers and rule lookup for the current state and symbol.
// ----------------------------------------------------------------------------
module tmse_rule_bank (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmse_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tmse_pkg::t_state                   i_state,
    input  tmse_pkg::t_symbol                  i_symbol,
    output tmse_pkg::t_rule                    o_rule,
    output tmse_pkg::t_count_cfg               o_limit
);
    import tmse_pkg::*;

    t_count_cfg            r_state_count;
    logic [CFG_DATA_W-1:0] r_rules [1:NUM_RULE_REGS];
    logic [CFG_DATA_W-1:0] w_row;
    logic [7:0]            w_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= STATE_COUNT_RESET;
            for (int k = 1; k <= NUM_RULE_REGS; k++) begin
                r_rules[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_STATE_COUNT) begin
                r_state_count <= i_cfg_data[3:0];
            end else begin
                r_rules[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        w_row = '0;
        for (int k = 1; k <= NUM_RULE_REGS; k++) begin
            if (i_state == 3'(k)) begin
                w_row = r_rules[k];
            end
        end
        if (i_symbol == SYM_INVALID) begin
            w_byte = '0;
        end else begin
            w_byte = w_row[{i_symbol, 3'b000} +: 8];
        end
    end

    assign o_rule.wr = w_byte[1:0];
    assign o_rule.mv = w_byte[3:2];
    assign o_rule.nx = w_byte[6:4];
    assign o_limit   = (r_state_count > 4'(NUM_STATES)) ? 4'(NUM_STATES) : r_state_count;

endmodule

// ===== sv/turing_machine_step_engine.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Three-symbol Turing machine: step and tape read commands on a stream port.
// ----------------------------------------------------------------------------
// One command is accepted every clock cycle while the result side does not
// stall, and its result passes the stage-1 register into the output register.
// Tape RAM reads are registered; the symbol under the head is held in a
// register and both neighbor cells are fetched on the two read ports while a
// command is accepted, so the read-decide-write loop closes without stalling
// the stream. The tape RAM is not cleared after reset: cells outside the
// visited span are never read, and the one visited cell that may still be
// unwritten is the head cell, which is served from the head register.
// Stalls only come from the result side.
module turing_machine_step_engine #(
    parameter int TAPE_CELLS = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // read_offset, pad
    input  logic                            s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // machine_state, halted, status, step_count, head_cell, leftmost_cell,
    // rightmost_cell, cell_symbol, pad
    output logic [79:0]                     m_axis_tdata
);
    import tmse_pkg::*;

    localparam int AW = $clog2(TAPE_CELLS);
    localparam int CW = (AW + 1 > OFFSET_W) ? AW + 1 : OFFSET_W;
    localparam logic [AW-1:0] MID_CELL  = AW'(TAPE_CELLS / 2);
    localparam logic [AW-1:0] LAST_CELL = AW'(TAPE_CELLS - 1);

    // machine state
    t_state               r_state,  n_state;
    t_status              r_fault,  n_fault;
    logic [AW-1:0]        r_head,   n_head;
    logic [AW-1:0]        r_left,   n_left;
    logic [AW-1:0]        r_right,  n_right;
    logic [COUNT_W-1:0]   r_count,  n_count;
    t_symbol              r_sym_head, n_sym_head;

    // pipeline stage and output register
    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic                 r_s1_off_bad;
    logic                 r_s1_at_head;
    logic                 r_o_valid;
    t_state               r_o_state;
    logic                 r_o_halted;
    t_status              r_o_status;
    logic [COUNT_W-1:0]   r_o_count;
    logic [AW-1:0]        r_o_head;
    logic [AW-1:0]        r_o_left;
    logic [AW-1:0]        r_o_right;
    t_symbol              r_o_sym;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_s1_fire;
    t_rule                w_rule;
    t_count_cfg           w_limit;
    t_symbol              w_rd_a;
    t_symbol              w_rd_b;
    logic                 w_live, w_cur_bad, w_rule_bad, w_end;
    logic                 w_step, w_apply, w_go_left, w_go_right, w_ext_l, w_ext_r;
    logic [AW-1:0]        w_hm1, w_hm2, w_hp1, w_hp2;
    logic [AW-1:0]        w_off;
    logic [AW-1:0]        w_rd_sum;
    logic [AW-1:0]        w_nh_m1, w_nh_p1;
    logic [AW-1:0]        w_rd_addr_a;
    logic [AW-1:0]        w_span;
    logic [CW-1:0]        w_off_w, w_span_w;
    logic                 w_off_bad;
    t_status              w_o_status;
    t_symbol              w_o_sym;

    tmse_rule_bank u_rule_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_state     (r_state),
        .i_symbol    (r_sym_head),
        .o_rule      (w_rule),
        .o_limit     (w_limit)
    );

    tmse_tape_ram #(
        .DEPTH (TAPE_CELLS),
        .AW    (AW)
    ) u_tape_ram (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_nh_p1),
        .i_wr_en     (w_apply),
        .i_wr_addr   (r_head),
        .i_wr_data   (w_rule.wr),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign w_s1_fire     = r_s1_valid && w_out_free;
    assign s_axis_tready = !r_s1_valid || w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_hm1 = r_head - AW'(1);
    assign w_hm2 = r_head - AW'(2);
    assign w_hp1 = r_head + AW'(1);
    assign w_hp2 = r_head + AW'(2);
    assign w_off = AW'(s_axis_tdata[OFFSET_W-1:0]);

    // transition decision
    always_comb begin
        w_live     = (r_state != STATE_HALT) && (r_fault == ST_OK);
        w_cur_bad  = {1'b0, r_state} >= w_limit;
        w_rule_bad = (w_rule.wr == SYM_INVALID) || (w_rule.mv == MOVE_BAD) ||
                     ((w_rule.nx != STATE_HALT) && ({1'b0, w_rule.nx} >= w_limit));
        w_end      = ((w_rule.mv == MOVE_LEFT) && (r_head == '0)) ||
                     ((w_rule.mv == MOVE_RIGHT) && (r_head == LAST_CELL));
        w_step     = w_s1_fire && (r_s1_cmd == CMD_STEP) && w_live;
        w_apply    = w_step && !w_cur_bad && !w_rule_bad && !w_end;
        w_go_left  = w_apply && (w_rule.mv == MOVE_LEFT);
        w_go_right = w_apply && (w_rule.mv == MOVE_RIGHT);
        w_ext_l    = w_go_left && (r_head == r_left);
        w_ext_r    = w_go_right && (r_head == r_right);

        n_fault = r_fault;
        if (w_step && (w_cur_bad || w_rule_bad)) begin
            n_fault = ST_BAD_RULE;
        end else if (w_step && w_end) begin
            n_fault = ST_TAPE_END;
        end

        n_head  = w_go_left ? w_hm1 : (w_go_right ? w_hp1 : r_head);
        n_left  = w_ext_l ? w_hm1 : r_left;
        n_right = w_ext_r ? w_hp1 : r_right;
        n_state = w_apply ? w_rule.nx : r_state;
        n_count = (w_apply && (r_count != '1)) ? r_count + COUNT_W'(1) : r_count;

        n_sym_head = r_sym_head;
        if (w_go_left) begin
            n_sym_head = w_ext_l ? SYM_BLANK : w_rd_a;
        end else if (w_go_right) begin
            n_sym_head = w_ext_r ? SYM_BLANK : w_rd_b;
        end else if (w_apply) begin
            n_sym_head = w_rule.wr;
        end

        if (r_s1_cmd == CMD_READ) begin
            w_o_status = r_s1_off_bad ? ST_READ_BEYOND : n_fault;
            w_o_sym    = r_s1_off_bad ? SYM_BLANK :
                         (r_s1_at_head ? r_sym_head : w_rd_a);
        end else begin
            w_o_status = n_fault;
            w_o_sym    = n_sym_head;
        end
    end

    // read addresses for the command being accepted, against the updated state
    always_comb begin
        w_nh_m1     = w_go_left ? w_hm2 : (w_go_right ? r_head : w_hm1);
        w_nh_p1     = w_go_left ? r_head : (w_go_right ? w_hp2 : w_hp1);
        w_rd_sum    = w_ext_l ? (w_hm1 + w_off) : (r_left + w_off);
        w_rd_addr_a = (s_axis_tuser == CMD_READ) ? w_rd_sum : w_nh_m1;
        w_span      = r_right - r_left;
        w_off_w     = CW'(s_axis_tdata[OFFSET_W-1:0]);
        w_span_w    = CW'(w_span) + ((w_ext_l || w_ext_r) ? CW'(1) : CW'(0));
        w_off_bad   = w_off_w > w_span_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= STATE_INIT;
            r_fault    <= ST_OK;
            r_head     <= MID_CELL;
            r_left     <= MID_CELL;
            r_right    <= MID_CELL;
            r_count    <= '0;
            r_sym_head <= SYM_BLANK;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fault    <= n_fault;
            r_head     <= n_head;
            r_left     <= n_left;
            r_right    <= n_right;
            r_count    <= n_count;
            r_sym_head <= n_sym_head;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd     <= s_axis_tuser;
            r_s1_off_bad <= w_off_bad;
            r_s1_at_head <= (w_rd_sum == n_head);
        end
        if (w_s1_fire) begin
            r_o_state  <= n_state;
            r_o_halted <= (n_state == STATE_HALT) || (n_fault != ST_OK);
            r_o_status <= w_o_status;
            r_o_count  <= n_count;
            r_o_head   <= n_head;
            r_o_left   <= n_left;
            r_o_right  <= n_right;
            r_o_sym    <= w_o_sym;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {4'b0000, r_o_sym,
                            FIELD_POS_W'(r_o_right), FIELD_POS_W'(r_o_left),
                            FIELD_POS_W'(r_o_head), r_o_count,
                            r_o_status, r_o_halted, r_o_state};

    a_fault_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != ST_OK) |=> (r_fault != ST_OK))
        else $error("recorded fault cleared without reset");

    a_head_in_span : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left <= r_head) && (r_head <= r_right))
        else $error("head outside visited span");

    a_halted_frozen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == STATE_HALT) || (r_fault != ST_OK)) |=>
        ($stable(r_count) && $stable(r_head)))
        else $error("halted machine advanced");

endmodule
